// ----- src/assert_macros.svh -----
// Assertion macros shared by the calibrator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define FFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define FFC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/ffc_pkg.sv -----
// Types and constants for the force plate frame calibrator.
package ffc_pkg;

	localparam int RX_W       = 8;
	localparam int IN_CH_W    = 4;
	localparam int OUT_CH_W   = 3;
	localparam int OUT_VAL_W  = 39;
	localparam int FRAC_BITS  = 22;
	localparam int RAW_W      = 13;
	localparam int NIBBLE_W   = 4;

	localparam logic signed [RAW_W-1:0] RAW_OFFSET = 13'sd2048;
	localparam logic [NIBBLE_W-1:0] TRIG_NIBBLE = 4'hF;
	localparam logic [NIBBLE_W-1:0] SYNC_NIBBLE = 4'h0;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_COEF = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ISSUE,
		ST_DRAIN,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic clr;
		logic en;
	} mac_ctrl_t;

	typedef struct packed {
		logic found;
		logic trigger;
	} win_status_t;

endpackage

// ----- src/force_plate_frame_calibrator_core.sv -----
// Top level of the force plate frame calibrator.
//
//   channel | signals                                              | direction
//   in      | in_valid, in_ready, operation, rx_byte,              | into block
//           | coef_in_channel, coef_out_channel, coef_value        |
//   out     | out_valid, out_ready, out_channel, out_value,        | out of block
//           | trigger, last                                        |
//
// A coefficient write is taken in ST_IDLE; a byte with no frame returns via ST_CHECK.
// Per output channel a frame runs ST_ISSUE, ST_DRAIN, ST_LOAD; the single multiplier
// walks the coefficient matrix one term per cycle in ST_ISSUE; ST_LOAD can stall.
// Reset loads the identity matrix at once through per-entry valid bits.
// A result waiting in the output register stalls only the next result of a frame.
module force_plate_frame_calibrator_core import ffc_pkg::*; #(
	parameter int IN_CHANNELS  = 12,
	parameter int OUT_CHANNELS = 6,
	parameter int COEF_WIDTH   = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic [RX_W-1:0]              rx_byte,
	input  logic [IN_CH_W-1:0]           coef_in_channel,
	input  logic [OUT_CH_W-1:0]          coef_out_channel,
	input  logic signed [COEF_WIDTH-1:0] coef_value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [OUT_CH_W-1:0]          out_channel,
	output logic signed [OUT_VAL_W-1:0]  out_value,
	output logic                         trigger,
	output logic                         last
);

	`include "assert_macros.svh"

	localparam int DEPTH  = IN_CHANNELS * OUT_CHANNELS;
	localparam int AW     = $clog2(DEPTH);
	localparam int IC_W   = $clog2(IN_CHANNELS);
	localparam int OC_W   = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
	localparam int MUL_CW = (COEF_WIDTH > FRAC_BITS + 2) ? COEF_WIDTH : FRAC_BITS + 2;
	localparam logic signed [MUL_CW-1:0] IDENT_COEF = MUL_CW'(64'd1 << FRAC_BITS);

	state_t state_q, state_d;
	logic [IC_W-1:0] ic_q;
	logic [OC_W-1:0] oc_q;
	logic drain_q;
	logic trig_q;
	logic ic_last, oc_last;

	logic accept, shift_en, wr_en, in_range, load_go;
	logic [AW-1:0] waddr, raddr;
	logic [DEPTH-1:0] cvalid_q;
	logic cvalid_s1, diag_s1, issue_s1;
	logic [COEF_WIDTH-1:0] ram_rdata;
	logic signed [MUL_CW-1:0] coef_s1;
	logic signed [RAW_W-1:0] raw_s1;
	logic signed [OUT_VAL_W-1:0] acc;
	win_status_t win_status;
	mac_ctrl_t mac_ctrl;

	logic out_valid_q, trigger_q, last_q;
	logic [OUT_CH_W-1:0] out_channel_q;
	logic signed [OUT_VAL_W-1:0] out_value_q;

	assign accept   = in_valid && in_ready;
	assign ic_last  = (ic_q == IC_W'(IN_CHANNELS - 1));
	assign oc_last  = (oc_q == OC_W'(OUT_CHANNELS - 1));
	assign in_range = (int'(coef_in_channel) < IN_CHANNELS)
		&& (int'(coef_out_channel) < OUT_CHANNELS);
	assign waddr = AW'(int'(coef_in_channel) * OUT_CHANNELS + int'(coef_out_channel));
	assign raddr = AW'(int'(ic_q) * OUT_CHANNELS + int'(oc_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && operation == OP_BYTE) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = win_status.found ? ST_ISSUE : ST_IDLE;
			end
			ST_ISSUE: begin
				if (ic_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (load_go) begin
					state_d = oc_last ? ST_IDLE : ST_ISSUE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		load_go      = 1'b0;
		mac_ctrl.clr = 1'b0;
		mac_ctrl.en  = issue_s1;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_CHECK: begin
				mac_ctrl.clr = 1'b1;
			end
			ST_LOAD: begin
				load_go      = !out_valid_q || out_ready;
				mac_ctrl.clr = load_go;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign shift_en = accept && operation == OP_BYTE;
	assign wr_en    = accept && operation == OP_COEF && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ic_q     <= '0;
			oc_q     <= '0;
			drain_q  <= 1'b0;
			trig_q   <= 1'b0;
			cvalid_q <= '0;
			issue_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= (state_q == ST_ISSUE);
			if (wr_en) begin
				cvalid_q[waddr] <= 1'b1;
			end
			if (state_q == ST_CHECK) begin
				trig_q <= win_status.trigger;
				ic_q   <= '0;
				oc_q   <= '0;
			end
			if (state_q == ST_ISSUE) begin
				ic_q    <= ic_last ? '0 : ic_q + IC_W'(1);
				drain_q <= 1'b0;
			end
			if (state_q == ST_DRAIN) begin
				drain_q <= 1'b1;
			end
			if (load_go && !oc_last) begin
				oc_q <= oc_q + OC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cvalid_s1 <= cvalid_q[raddr];
		diag_s1   <= (int'(ic_q) == int'(oc_q));
	end

	ffc_ram #(
		.WIDTH(COEF_WIDTH),
		.DEPTH(DEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(coef_value),
		.re   (state_q == ST_ISSUE),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (cvalid_s1) begin
			coef_s1 = MUL_CW'($signed(ram_rdata));
		end else if (diag_s1) begin
			coef_s1 = IDENT_COEF;
		end else begin
			coef_s1 = '0;
		end
	end

	ffc_window #(
		.IN_CHANNELS(IN_CHANNELS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift_en(shift_en),
		.rx_byte (rx_byte),
		.sel     (ic_q),
		.status  (win_status),
		.raw_s1  (raw_s1)
	);

	ffc_mac #(
		.B_W(MUL_CW)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (mac_ctrl),
		.a     (raw_s1),
		.b     (coef_s1),
		.acc   (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_go) begin
			out_channel_q <= OUT_CH_W'(oc_q);
			out_value_q   <= acc;
			trigger_q     <= trig_q;
			last_q        <= oc_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign out_value   = out_value_q;
	assign trigger     = trigger_q;
	assign last        = last_q;

	`FFC_ASSERT(a_check_after_byte, (state_q == ST_CHECK) |-> $past(shift_en), "frame check without a byte")
	`FFC_NEVER(a_mac_outside_frame, mac_ctrl.en && state_q != ST_ISSUE && state_q != ST_DRAIN, "product issued outside a frame")
	`FFC_ASSERT(a_last_channel, (out_valid && last) |-> (out_channel == OUT_CH_W'(OUT_CHANNELS - 1)), "last flag on wrong channel")

endmodule

// ----- src/ffc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ffc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/ffc_window.sv -----
// Byte window with frame detection and raw channel value selection.
module ffc_window import ffc_pkg::*; #(
	parameter int IN_CHANNELS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift_en,
	input  logic [RX_W-1:0]                rx_byte,
	input  logic [$clog2(IN_CHANNELS)-1:0] sel,
	output win_status_t                    status,
	output logic signed [RAW_W-1:0]        raw_s1
);

	localparam int WB = 2 * IN_CHANNELS;

	logic [RX_W-1:0] win_q [WB];
	logic [15:0] word [IN_CHANNELS];
	logic [NIBBLE_W-1:0] n0;
	logic match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WB; k++) begin
				win_q[k] <= '0;
			end
		end else if (shift_en) begin
			for (int k = 0; k < WB - 1; k++) begin
				win_q[k] <= win_q[k+1];
			end
			win_q[WB-1] <= rx_byte;
		end
	end

	for (genvar g = 0; g < IN_CHANNELS; g++) begin : g_word
		assign word[g] = {win_q[2*g+1], win_q[2*g]};
	end

	assign n0 = word[0][15:12];

	always_comb begin
		match = 1'b1;
		for (int k = 1; k < IN_CHANNELS; k++) begin
			if (word[k][15:12] != NIBBLE_W'(k)) begin
				match = 1'b0;
			end
		end
	end

	assign status.found   = match && (n0 == SYNC_NIBBLE || n0 == TRIG_NIBBLE);
	assign status.trigger = (n0 == TRIG_NIBBLE);

	always_ff @(posedge clk) begin
		raw_s1 <= $signed({1'b0, word[sel][11:0]}) - RAW_OFFSET;
	end

endmodule

// ----- src/ffc_mac.sv -----
// Shared multiply-accumulate unit with a registered product stage.
module ffc_mac import ffc_pkg::*; #(
	parameter int B_W = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mac_ctrl_t                    ctrl,
	input  logic signed [RAW_W-1:0]      a,
	input  logic signed [B_W-1:0]        b,
	output logic signed [OUT_VAL_W-1:0]  acc
);

	localparam int PROD_W = RAW_W + B_W;
	localparam int EXT_W  = (PROD_W > OUT_VAL_W) ? PROD_W : OUT_VAL_W;

	logic signed [PROD_W-1:0] prod_s2;
	logic en_s2;
	logic signed [EXT_W-1:0] prod_ext;
	logic signed [OUT_VAL_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_s2 <= a * b;
		end
	end

	assign prod_ext = EXT_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			en_s2 <= ctrl.en;
			if (ctrl.clr) begin
				acc_q <= '0;
			end else if (en_s2) begin
				acc_q <= acc_q + prod_ext[OUT_VAL_W-1:0];
			end
		end
	end

	assign acc = acc_q;

endmodule
